// ----- sv/ritoa_pkg.sv -----
package ritoa_pkg;

   localparam int NUMBER_WIDTH   = 32;
   localparam int RADIX_WIDTH    = 6;
   localparam int DIGIT_WIDTH    = 6;
   localparam int CHAR_WIDTH     = 7;
   localparam int REQ_DATA_WIDTH = 32;
   localparam int RSP_DATA_WIDTH = 8;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int MAX_DIGITS_DEFAULT = 32;

   localparam int STEP_BITS = 8;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 7'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 7'd57;
   localparam logic [CHAR_WIDTH-1:0] CHAR_A_SHIFT = 7'd87;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LAST    = 7'd122;

   function automatic logic [CHAR_WIDTH-1:0] digit_to_char(input logic [DIGIT_WIDTH-1:0] digit);
      logic [DIGIT_WIDTH-1:0] d;
      d = (digit > DIGIT_WIDTH'(35)) ? DIGIT_WIDTH'(35) : digit;
      if (d < DIGIT_WIDTH'(10)) begin
         digit_to_char = CHAR_ZERO + CHAR_WIDTH'(d);
      end else begin
         digit_to_char = CHAR_A_SHIFT + CHAR_WIDTH'(d);
      end
   endfunction

   function automatic logic [RADIX_WIDTH-1:0] clamp_radix(input logic [RADIX_WIDTH-1:0] value);
      if (value < RADIX_MIN) begin
         clamp_radix = RADIX_MIN;
      end else if (value > RADIX_MAX) begin
         clamp_radix = RADIX_MAX;
      end else begin
         clamp_radix = value;
      end
   endfunction

endpackage

// ----- sv/ritoa_front.sv -----
module ritoa_front #(
   parameter int VALUE_BITS = ritoa_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [31:0] number
   input  logic [ritoa_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                  q_valid,
   input  logic                                  q_ready,
   output logic [VALUE_BITS-1:0]                 q_number
);

   localparam int IN_BITS = (VALUE_BITS < ritoa_pkg::NUMBER_WIDTH) ?
                            VALUE_BITS : ritoa_pkg::NUMBER_WIDTH;

   logic [VALUE_BITS-1:0] slot_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push, pop;
   logic [VALUE_BITS-1:0] number_masked;

   assign number_masked = VALUE_BITS'(req_tdata[IN_BITS-1:0]);
   assign req_tready    = (count_ff != 2'd2);
   assign q_valid       = (count_ff != 2'd0);
   assign q_number      = slot_ff[rd_ptr_ff];
   assign push          = req_tvalid && req_tready;
   assign pop           = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= number_masked;
      end
   end

endmodule

// ----- sv/ritoa_back.sv -----
module ritoa_back #(
   parameter int VALUE_BITS = ritoa_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_DIGITS = ritoa_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ritoa_pkg::RADIX_WIDTH-1:0]  radix,
   input  logic                               q_valid,
   output logic                               q_ready,
   input  logic [VALUE_BITS-1:0]              q_number,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [6:0] character, [7] zero
   output logic [ritoa_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int DW         = ritoa_pkg::DIGIT_WIDTH;
   localparam int SB         = ritoa_pkg::STEP_BITS;
   localparam int DIV_CYCLES = (VALUE_BITS + SB - 1) / SB;
   localparam int PAD_BITS   = DIV_CYCLES * SB;
   localparam int SW         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int CW         = $clog2(MAX_DIGITS + 1);
   localparam int AW         = $clog2(MAX_DIGITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PREP,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [PAD_BITS-1:0] quo_ff, quo_in;
   logic [SW-1:0]       step_ff, step_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [DW-1:0]       rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                mem_we;
   logic [DW-1:0]       digit_mem [MAX_DIGITS];

   logic [DW-1:0]       rem_step;
   logic [PAD_BITS-1:0] quo_step;

   always_comb begin : div_step
      logic [DW:0]         trial;
      logic [DW-1:0]       r;
      logic [PAD_BITS-1:0] q;
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < SB; i++) begin
         trial = {r, q[PAD_BITS-1]};
         if (trial >= {1'b0, radix}) begin
            r = DW'(trial - {1'b0, radix});
            q = {q[PAD_BITS-2:0], 1'b1};
         end else begin
            r = trial[DW-1:0];
            q = {q[PAD_BITS-2:0], 1'b0};
         end
      end
      rem_step = r;
      quo_step = q;
   end

   assign q_ready    = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {1'b0, ritoa_pkg::digit_to_char(rd_data_ff)};
   assign rsp_tlast  = (ptr_ff == '0);

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      rd_addr  = ptr_ff;
      mem_we   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               quo_in   = PAD_BITS'(q_number);
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            quo_in = quo_step;
            rem_in = rem_step;
            if (step_ff == SW'(DIV_CYCLES - 1)) begin
               mem_we  = 1'b1;
               cnt_in  = cnt_ff + CW'(1);
               rem_in  = '0;
               step_in = '0;
               if ((quo_step == '0) || (cnt_ff + CW'(1) == CW'(MAX_DIGITS))) begin
                  ptr_in   = cnt_ff[AW-1:0];
                  state_in = ST_PREP;
               end
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_PREP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in  = ptr_ff - AW'(1);
                  rd_addr = ptr_ff - AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         cnt_ff   <= '0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         ptr_ff   <= ptr_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[cnt_ff[AW-1:0]] <= rem_step;
      end
      rd_data_ff <= digit_mem[rd_addr];
   end

endmodule

// ----- sv/radix_integer_to_ascii.sv -----
// Each number is worked by the shared divider, which retires eight quotient bits per cycle;
// then one character leaves per cycle while rsp_tready is high.
// A two-entry queue takes new numbers while the divider or the output is busy.
// Reset is synchronous and active high; it sets the radix to 10 and empties the queue.
module radix_integer_to_ascii #(
   parameter int VALUE_BITS = ritoa_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_DIGITS = ritoa_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [31:0] number
   input  logic [ritoa_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [6:0] character, [7] zero
   output logic [ritoa_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ritoa_pkg::RADIX_WIDTH-1:0]     csr_data
);

   logic [ritoa_pkg::RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic                              q_valid;
   logic                              q_ready;
   logic [VALUE_BITS-1:0]             q_number;

   assign csr_ready = 1'b1;
   assign radix_in  = (csr_valid && csr_ready) ? ritoa_pkg::clamp_radix(csr_data) : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= ritoa_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   ritoa_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_number   (q_number)
   );

   ritoa_back #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .radix      (radix_ff),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_number   (q_number),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_radix_range : assert property (@(posedge clock) disable iff (reset)
      (radix_ff >= ritoa_pkg::RADIX_MIN) && (radix_ff <= ritoa_pkg::RADIX_MAX))
      else $error("Radix register left its legal range.");

   a_char_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[ritoa_pkg::CHAR_WIDTH-1:0] >= ritoa_pkg::CHAR_ZERO) &&
                     (rsp_tdata[ritoa_pkg::CHAR_WIDTH-1:0] <= ritoa_pkg::CHAR_LAST))
      else $error("Output character is not a digit or lowercase letter.");

   a_digit_below_radix : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ((rsp_tdata[ritoa_pkg::CHAR_WIDTH-1:0] <= ritoa_pkg::CHAR_NINE) ?
             (rsp_tdata[ritoa_pkg::CHAR_WIDTH-1:0] - ritoa_pkg::CHAR_ZERO) :
             (rsp_tdata[ritoa_pkg::CHAR_WIDTH-1:0] - ritoa_pkg::CHAR_A_SHIFT))
         < ritoa_pkg::CHAR_WIDTH'(radix_ff))
      else $error("Emitted digit is not below the radix.");

endmodule
